// ===== rtl/core/max_compatible_subset_bitmask_dp_defines.svh =====
// ----------------------------------------------------------------------------
// Max compatible subset assertion macros
// Shared property forms for the checker of the subset search block.
// ----------------------------------------------------------------------------
`ifndef MAX_COMPATIBLE_SUBSET_BITMASK_DP_DEFINES_SVH
`define MAX_COMPATIBLE_SUBSET_BITMASK_DP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Max compatible subset package
// Sizes, command codes and shared types of the subset search block.
// ----------------------------------------------------------------------------
package mcs_pkg;

    // Number of people the conflict matrix holds.
    localparam int MAX_PEOPLE = 12;

    // Fixed field widths.
    localparam int OPCODE_W = 2;
    localparam int PERSON_W = 4;
    localparam int CFG_W    = 4;
    localparam int SIZE_W   = 4;
    localparam int MASK_W   = 12;

    // Derived sizes.
    localparam int COUNT_W     = $clog2(MAX_PEOPLE + 1);
    localparam int TABLE_DEPTH = 1 << MAX_PEOPLE;

    // Command codes.
    localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;

    // Reset value of the people count register.
    localparam logic [CFG_W-1:0] PEOPLE_RESET = CFG_W'(MAX_PEOPLE);

    typedef logic [MAX_PEOPLE-1:0]                 subset_t;
    typedef logic [MAX_PEOPLE-1:0][MAX_PEOPLE-1:0] matrix_t;

    // Result of checking one subset against the conflict matrix.
    typedef struct packed {
        logic                 conflict_free;
        logic [COUNT_W-1:0]   count;
        subset_t              rest;
        logic                 rest_empty;
    } eval_t;

endpackage

// ===== rtl/core/mcs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface mcs_cmd_if;
    import mcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PERSON_W-1:0] person_a;
    logic [PERSON_W-1:0] person_b;

    modport source (output valid, output opcode, output person_a, output person_b,
                    input ready);
    modport sink (input valid, input opcode, input person_a, input person_b,
                  output ready);
endinterface

// ===== rtl/core/mcs_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface mcs_res_if;
    import mcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] best_size;
    logic [MASK_W-1:0] best_mask;

    modport source (output valid, output best_size, output best_mask, input ready);
    modport sink (input valid, input best_size, input best_mask, output ready);
endinterface

// ===== rtl/core/max_compatible_subset_bitmask_dp.sv =====
// Add and clear update the conflict matrix; a compute walks subsets 1 to 2^n - 1 and
// then gives the result beat, n being people_count capped at MAX_PEOPLE.
// Subsets are checked one at a time, each waiting in ST_READ on the registered read
// of the valid-subset RAM; no new command during a compute.
// Reset clears the conflict matrix, the control state and sets people_count
// to 12; the valid-subset RAM is not cleared, each entry is written before use.
// ----------------------------------------------------------------------------
// Max compatible subset search
// Loads or clears conflict pairs, then walks all subsets to find the largest valid one.
// ----------------------------------------------------------------------------
module max_compatible_subset_bitmask_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mcs_pkg::CFG_W-1:0] cfg_wdata,
    mcs_cmd_if.sink                   cmd,
    mcs_res_if.source                 result
);
    import mcs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg,      state_next;
    subset_t            subset_reg,     subset_next;
    subset_t            last_reg,       last_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    subset_t            best_mask_reg,  best_mask_next;
    logic               free_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               rest_empty_reg;
    matrix_t            matrix_reg,     matrix_next;
    logic [CFG_W-1:0]   people_reg;
    logic               out_valid_reg,  out_valid_next;
    logic [SIZE_W-1:0]  out_size_reg,   out_size_next;
    logic [MASK_W-1:0]  out_mask_reg,   out_mask_next;

    eval_t              eval;
    logic               cmd_fire;
    logic               ram_we;
    logic               ram_rdata;
    logic               subset_ok;
    logic [CFG_W-1:0]   people_sat;
    logic [MAX_PEOPLE:0] limit;

    // Shared subset checker.
    mcs_eval u_eval (
        .subset (subset_reg),
        .matrix (matrix_reg),
        .result (eval)
    );

    // Valid-subset table, one bit per subset.
    mcs_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (subset_reg),
        .wdata (subset_ok),
        .raddr (eval.rest),
        .rdata (ram_rdata)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign ram_we    = (state_reg == ST_EVAL);
    assign subset_ok = free_reg && (rest_empty_reg || ram_rdata);

    // Capped people_count, and one past the highest subset (its low people_count bits set).
    assign people_sat = (people_reg > CFG_W'(MAX_PEOPLE)) ? CFG_W'(MAX_PEOPLE) : people_reg;
    assign limit      = (MAX_PEOPLE + 1)'(1) << people_sat;

    // Sequencer and conflict matrix updates.
    always_comb
    begin
        state_next      = state_reg;
        subset_next     = subset_reg;
        last_next       = last_reg;
        best_count_next = best_count_reg;
        best_mask_next  = best_mask_reg;
        matrix_next     = matrix_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_size_next   = out_size_reg;
        out_mask_next   = out_mask_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.opcode == OP_ADD)
                    begin
                        if ((cmd.person_a < PERSON_W'(MAX_PEOPLE))
                            && (cmd.person_b < PERSON_W'(MAX_PEOPLE)))
                        begin
                            for (int r = 0; r < MAX_PEOPLE; r++)
                            begin
                                for (int c = 0; c < MAX_PEOPLE; c++)
                                begin
                                    if (((cmd.person_a == PERSON_W'(r))
                                         && (cmd.person_b == PERSON_W'(c)))
                                        || ((cmd.person_b == PERSON_W'(r))
                                         && (cmd.person_a == PERSON_W'(c))))
                                    begin
                                        matrix_next[r][c] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    else if (cmd.opcode == OP_CLEAR)
                    begin
                        matrix_next = '0;
                    end
                    else if (cmd.opcode == OP_COMPUTE)
                    begin
                        best_count_next = '0;
                        best_mask_next  = '0;
                        last_next       = limit[MAX_PEOPLE-1:0] - MAX_PEOPLE'(1);
                        subset_next     = MAX_PEOPLE'(1);
                        if (limit[MAX_PEOPLE-1:0] == MAX_PEOPLE'(1))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (subset_ok && (count_reg > best_count_reg))
                begin
                    best_count_next = count_reg;
                    best_mask_next  = subset_reg;
                end
                if (subset_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    subset_next = subset_reg + MAX_PEOPLE'(1);
                    state_next  = ST_READ;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_size_next  = SIZE_W'(best_count_reg);
                    out_mask_next  = MASK_W'(best_mask_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, matrix and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            matrix_reg     <= '0;
            people_reg     <= PEOPLE_RESET;
            best_count_reg <= '0;
            best_mask_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            matrix_reg     <= matrix_next;
            best_count_reg <= best_count_next;
            best_mask_reg  <= best_mask_next;
            if (cfg_we)
            begin
                people_reg <= cfg_wdata;
            end
        end
    end

    // Walk and output payload registers.
    always_ff @(posedge clk)
    begin
        subset_reg   <= subset_next;
        last_reg     <= last_next;
        out_size_reg <= out_size_next;
        out_mask_reg <= out_mask_next;
        if (state_reg == ST_READ)
        begin
            free_reg       <= eval.conflict_free;
            count_reg      <= eval.count;
            rest_empty_reg <= eval.rest_empty;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.best_size = out_size_reg;
    assign result.best_mask = out_mask_reg;
endmodule

// ===== rtl/core/mcs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/mcs_eval.sv =====
// ----------------------------------------------------------------------------
// Subset evaluation unit
// Checks the lowest member of a subset against the subset and counts members.
// ----------------------------------------------------------------------------
module mcs_eval (
    input  mcs_pkg::subset_t subset,
    input  mcs_pkg::matrix_t matrix,
    output mcs_pkg::eval_t   result
);
    import mcs_pkg::*;

    subset_t            low_oh;
    subset_t            row_sel;
    logic [COUNT_W-1:0] count;

    // One-hot of the lowest member; the subset without it is formed below.
    assign low_oh = subset & (~subset + MAX_PEOPLE'(1));

    // Pick the conflict row of the lowest member.
    always_comb
    begin
        row_sel = '0;
        for (int r = 0; r < MAX_PEOPLE; r++)
        begin
            if (low_oh[r])
            begin
                row_sel = row_sel | matrix[r];
            end
        end
    end

    // Population count of the subset.
    always_comb
    begin
        count = '0;
        for (int i = 0; i < MAX_PEOPLE; i++)
        begin
            count = count + COUNT_W'(subset[i]);
        end
    end

    assign result.conflict_free = ((row_sel & subset) == '0);
    assign result.count         = count;
    assign result.rest          = subset & ~low_oh;
    assign result.rest_empty    = ((subset & ~low_oh) == '0);
endmodule

// ===== rtl/core/mcs_checker.sv =====
// ----------------------------------------------------------------------------
// Max compatible subset checker
// Port-level properties of the subset search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_compatible_subset_bitmask_dp_defines.svh"

module mcs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic [mcs_pkg::OPCODE_W-1:0] cmd_opcode,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [mcs_pkg::SIZE_W-1:0]   best_size,
    input logic [mcs_pkg::MASK_W-1:0]   best_mask
);
    import mcs_pkg::*;

    // A stalled result beat holds its payload.
    `MCS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(best_size) && $stable(best_mask), "stalled result changed")

    // The reported size is the member count of the reported mask.
    `MCS_ASSERT_SAME(a_size_mask, clk, rst_n, res_valid, $countones(best_mask) == best_size, "size does not match mask")

    // A compute beat makes the block busy in the next cycle.
    `MCS_ASSERT_NEXT(a_busy, clk, rst_n, cmd_valid && cmd_ready && (cmd_opcode == OP_COMPUTE), !cmd_ready, "ready after compute")

    // A new result only rises out of a busy state, never while idle.
    `MCS_ASSERT_SAME(a_res_after_busy, clk, rst_n, $rose(res_valid), !$past(cmd_ready), "result while idle")
endmodule

bind max_compatible_subset_bitmask_dp mcs_checker u_mcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_opcode (cmd.opcode),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .best_size  (result.best_size),
    .best_mask  (result.best_mask)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Max compatible subset search testbench
// Feeds conflict adds, clears, unused opcodes and compute commands over many people counts,
// predicts every compute answer with an independent subset walk, and checks
// each result beat against it under random idling and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
    import mcs_pkg::*;

    // Command code the block has no use for.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int TAIL_ITEMS    = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int QUIET_LIMIT   = 40000;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PERSON_W-1:0] person_a;
        logic [PERSON_W-1:0] person_b;
    } command_t;

    typedef struct packed {
        logic [SIZE_W-1:0] best_size;
        logic [MASK_W-1:0] best_mask;
    } answer_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    mcs_cmd_if cmd_ch ();
    mcs_res_if res_ch ();

    max_compatible_subset_bitmask_dp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    // Commands waiting to be driven and compute answers waiting to come back.
    command_t pending_cmds [$];
    answer_t  awaited_answers [$];

    // Shadow copy of the block state used for prediction.
    subset_t          conflict_rows [MAX_PEOPLE];
    bit               subset_ok [TABLE_DEPTH];
    logic [CFG_W-1:0] people_setting = PEOPLE_RESET;

    // Idling control shared by the driver, the receiver and the stimulus.
    bit idle_en   = 1'b1;
    bit hold_req  = 1'b0;
    int send_gap  = 0;
    int stall_left = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Run statistics.
    int adds_seen       = 0;
    int computes_seen   = 0;
    int clears_seen     = 0;
    int ignored_seen    = 0;
    int answers_checked = 0;
    int mismatch_count  = 0;
    int settings_used   = 0;

    // Walk all subsets of the active people and return the first largest
    // subset in which nobody conflicts with anybody, themselves included.
    function automatic answer_t search_best_subset();
        int unsigned span;
        int unsigned s;
        int unsigned low;
        subset_t     members;
        logic        ok;
        answer_t     best;
        span = (people_setting > MAX_PEOPLE) ? MAX_PEOPLE : people_setting;
        best = '0;
        subset_ok[0] = 1'b1;
        for (s = 1; s < (1 << span); s++)
        begin
            members = subset_t'(s);
            low = 0;
            while (!members[low])
                low++;
            ok = subset_ok[s & (s - 1)] && ((conflict_rows[low] & members) == '0);
            subset_ok[s] = ok;
            if (ok && $countones(members) > best.best_size)
            begin
                best.best_size = SIZE_W'($countones(members));
                best.best_mask = MASK_W'(members);
            end
        end
        return best;
    endfunction

    // Update the shadow state for one accepted command beat.
    function automatic void apply_command(input command_t c);
        int i;
        case (c.opcode)
            OP_ADD:
            begin
                if (c.person_a < MAX_PEOPLE && c.person_b < MAX_PEOPLE)
                begin
                    conflict_rows[c.person_a][c.person_b] = 1'b1;
                    conflict_rows[c.person_b][c.person_a] = 1'b1;
                    adds_seen++;
                end
                else
                begin
                    ignored_seen++;
                end
            end
            OP_COMPUTE:
            begin
                awaited_answers = {awaited_answers, search_best_subset()};
                computes_seen++;
            end
            OP_CLEAR:
            begin
                for (i = 0; i < MAX_PEOPLE; i++)
                    conflict_rows[i] = '0;
                clears_seen++;
            end
            default:
            begin
                ignored_seen++;
            end
        endcase
    endfunction

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : reset_and_defaults
        int i;
        for (i = 0; i < MAX_PEOPLE; i++)
            conflict_rows[i] = '0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.opcode    = OP_ADD;
        cmd_ch.person_a  = '0;
        cmd_ch.person_b  = '0;
        res_ch.ready     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Command driver: keeps a beat steady until it is taken, then either
    // idles for a short burst or offers the next pending command.
    always @(posedge clk)
    begin : drive_commands
        command_t taken;
        command_t next_cmd;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken.opcode   = cmd_ch.opcode;
                taken.person_a = cmd_ch.person_a;
                taken.person_b = cmd_ch.person_b;
                apply_command(taken);
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd = pending_cmds[0];
                    pending_cmds.delete(0);
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.opcode   <= next_cmd.opcode;
                    cmd_ch.person_a <= next_cmd.person_a;
                    cmd_ch.person_b <= next_cmd.person_b;
                    if (idle_en && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 3);
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks each beat against the oldest predicted answer
    // and drives ready with short random stalls or one requested long hold.
    always @(posedge clk)
    begin : check_answers
        answer_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                answers_checked++;
                if (awaited_answers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result beat with no compute pending: size %0d mask %03h",
                                 $realtime, res_ch.best_size, res_ch.best_mask);
                end
                else
                begin
                    want = awaited_answers[0];
                    awaited_answers.delete(0);
                    if (want.best_size !== res_ch.best_size ||
                        want.best_mask !== res_ch.best_mask)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: answer mismatch: expected size %0d mask %03h, got size %0d mask %03h",
                                     $realtime, want.best_size, want.best_mask,
                                     res_ch.best_size, res_ch.best_mask);
                    end
                end
            end
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_command(input logic [OPCODE_W-1:0] op, input int a, input int b);
        command_t c;
        c.opcode   = op;
        c.person_a = PERSON_W'(a);
        c.person_b = PERSON_W'(b);
        pending_cmds = {pending_cmds, c};
    endtask

    // Wait until every command is taken and every answer is back, then give
    // a last add or clear time to land before the register changes.
    task automatic settle_block();
        while (pending_cmds.size() != 0 || awaited_answers.size() != 0 || cmd_ch.valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_people(input int count);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(count);
        @(posedge clk);
        cfg_we    <= 1'b0;
        people_setting = CFG_W'(count);
        settings_used++;
        @(negedge clk);
    endtask

    // Queue one phase of mostly well-formed conflict building with computes
    // spread through it; noise and ignored commands are mixed in.
    task automatic plan_phase(input int count, input int wanted, input int cap,
                              output int made);
        int span;
        int pick;
        int roll;
        int computes;
        int a;
        int b;
        span = (count > MAX_PEOPLE) ? MAX_PEOPLE : count;
        pick = (span < 2) ? 2 : span;
        made = 0;
        computes = 0;
        while (made < wanted)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8 && computes < cap)
            begin
                queue_command(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15));
                computes++;
                made++;
            end
            else if (roll < 10)
            begin
                queue_command(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
                made++;
            end
            else if (roll < 12)
            begin
                queue_command(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15));
            end
            else if (roll < 17)
            begin
                a = $urandom_range(0, 15);
                b = $urandom_range(0, 15);
                queue_command(OP_ADD, a, b);
                if (a < MAX_PEOPLE && b < MAX_PEOPLE)
                    made++;
            end
            else if (roll < 20)
            begin
                a = $urandom_range(0, pick - 1);
                queue_command(OP_ADD, a, a);
                made++;
            end
            else
            begin
                queue_command(OP_ADD, $urandom_range(0, pick - 1), $urandom_range(0, pick - 1));
                made++;
            end
        end
        // Close the phase with a compute, if the cap allows, so its final matrix is checked.
        if (computes < cap)
        begin
            queue_command(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15));
            made++;
        end
    endtask

    initial
    begin : stimulus
        int random_done;
        int phase;
        int count;
        int cap;
        int made;
        random_done = 0;
        phase = 0;
        @(posedge rst_n);
        repeat (3) @(negedge clk);

        // Directed part, starting from the reset people count of twelve:
        // empty matrix, self conflict, out-of-range persons, unused opcode,
        // clear, and then the register extremes.
        queue_command(OP_COMPUTE, 0, 0);
        queue_command(OP_ADD, 0, 0);
        queue_command(OP_ADD, 11, 5);
        queue_command(OP_ADD, 15, 15);
        queue_command(OP_ADD, 12, 3);
        queue_command(OP_ADD, 3, 14);
        queue_command(OP_UNUSED, 15, 15);
        queue_command(OP_COMPUTE, 15, 15);
        queue_command(OP_CLEAR, 0, 0);
        queue_command(OP_COMPUTE, 0, 0);
        settle_block();

        // No people at all, and a pair stored beyond the people count.
        set_people(0);
        queue_command(OP_COMPUTE, 0, 0);
        queue_command(OP_ADD, 7, 9);
        settle_block();

        // One person who conflicts with himself leaves no valid subset.
        set_people(1);
        queue_command(OP_ADD, 0, 0);
        queue_command(OP_COMPUTE, 0, 0);
        settle_block();

        // A count above the maximum saturates and brings the stored pair in.
        set_people(15);
        queue_command(OP_ADD, 10, 11);
        queue_command(OP_COMPUTE, 0, 0);
        settle_block();

        // Random phases, each with its own people count.
        while (random_done < RANDOM_ITEMS)
        begin
            settle_block();
            if (RANDOM_ITEMS - random_done <= TAIL_ITEMS)
                idle_en = 1'b0;
            if (phase == 3)
            begin
                // Long receiver hold while small computes keep coming.
                set_people(3);
                hold_req = 1'b1;
                plan_phase(3, 60, 12, made);
            end
            else
            begin
                if (phase % 6 == 5)
                begin
                    count = $urandom_range(9, 15);
                    cap = 2;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    count = 0;
                    cap = 20;
                end
                else
                begin
                    count = $urandom_range(1, 8);
                    cap = 20;
                end
                set_people(count);
                plan_phase(count, $urandom_range(40, 100), cap, made);
            end
            random_done += made;
            phase++;
        end

        settle_block();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (awaited_answers.size() != 0)
            $display("%0d predicted answers never arrived", awaited_answers.size());
        $display("Covered %0d stored adds, %0d computes, %0d clears, %0d ignored commands over %0d people settings.",
                 adds_seen, computes_seen, clears_seen, ignored_seen, settings_used);
        $display("Checked %0d result beats with %0d mismatches.", answers_checked, mismatch_count);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mcs_pkg.sv
rtl/core/mcs_cmd_if.sv
rtl/core/mcs_res_if.sv
rtl/core/mcs_ram.sv
rtl/core/mcs_eval.sv
rtl/core/max_compatible_subset_bitmask_dp.sv
rtl/core/mcs_checker.sv
test/tb_top.sv
